// ----- rtl/core/nmea_rmc_field_extractor_assert.svh -----
// Assertion macros for the NMEA RMC field extractor.
// No dependencies; included by files that carry concurrent checks.
`ifndef NMEA_RMC_FIELD_EXTRACTOR_ASSERT_SVH
`define NMEA_RMC_FIELD_EXTRACTOR_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled in reset.
`define NRMC_ASSERT_IMP(lbl, clk, rst, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, disabled in reset.
`define NRMC_ASSERT_NXT(lbl, clk, rst, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (cons)) \
    else $error("assertion failed");
`else
`define NRMC_ASSERT_IMP(lbl, clk, rst, ant, cons)
`define NRMC_ASSERT_NXT(lbl, clk, rst, ant, cons)
`endif
`endif

// ----- rtl/core/nrmc_pkg.sv -----
// Shared constants and types for the NMEA RMC field extractor.
// No dependencies.
package nrmc_pkg;

  localparam int MAX_LINE   = 250;
  localparam int LAST_FIELD = 8;
  // line position must hold MAX_LINE itself
  localparam int LPW        = $clog2(MAX_LINE + 1);

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_C      = 8'h43;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_V      = 8'h56;

  localparam logic [3:0] FIELD_MAX  = 4'hF;
  localparam logic [7:0] OFFSET_MAX = 8'hFF;
  localparam logic [3:0] FIX_FIELD  = 4'd2;

  typedef struct packed {
    logic [3:0] field_number;
    logic [7:0] char_offset;
    logic [7:0] data_byte;
    logic       field_char;
    logic       field_end;
    logic       sentence_done;
    logic       fix_valid;
  } result_t;

endpackage

// ----- rtl/core/nrmc_parser.sv -----
// Line tracker and field tagger: sentence state plus per-byte tagging logic.
// Depends on nrmc_pkg.
module nrmc_parser import nrmc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic [7:0] rx_byte,
  output result_t    result,
  output logic       line_open
);

  logic [LPW-1:0] line_pos, line_pos_next;
  logic           open_next;
  logic           byte4_m, byte4_m_next;
  logic           byte5_c, byte5_c_next;
  logic [3:0]     cur_field, cur_field_next;
  logic [7:0]     offset, offset_next;
  logic           pending_fix, pending_fix_next;
  logic           committed_fix, committed_fix_next;

  logic           is_dollar, is_comma, is_lf;
  logic           b4_upd, b5_upd, rmc, in_range;
  logic [LPW-1:0] pos_inc;

  assign is_dollar = (rx_byte == CH_DOLLAR);
  assign is_comma  = (rx_byte == CH_COMMA);
  assign is_lf     = (rx_byte == CH_LF);
  assign b4_upd    = (line_pos == LPW'(4)) ? (rx_byte == CH_M) : byte4_m;
  assign b5_upd    = (line_pos == LPW'(5)) ? (rx_byte == CH_C) : byte5_c;
  assign rmc       = b4_upd & b5_upd;
  assign in_range  = (cur_field >= 4'd1) && (cur_field <= 4'(LAST_FIELD));
  assign pos_inc   = line_pos + LPW'(1);

  always_comb begin
    open_next          = line_open;
    line_pos_next      = line_pos;
    byte4_m_next       = byte4_m;
    byte5_c_next       = byte5_c;
    cur_field_next     = cur_field;
    offset_next        = offset;
    pending_fix_next   = pending_fix;
    committed_fix_next = committed_fix;
    result.field_number  = 4'd0;
    result.char_offset   = 8'd0;
    result.data_byte     = rx_byte;
    result.field_char    = 1'b0;
    result.field_end     = 1'b0;
    result.sentence_done = 1'b0;
    if (is_dollar) begin
      open_next        = 1'b1;
      line_pos_next    = LPW'(1);
      byte4_m_next     = 1'b0;
      byte5_c_next     = 1'b0;
      cur_field_next   = 4'd0;
      offset_next      = 8'd0;
      pending_fix_next = committed_fix;
    end else if (line_open) begin
      result.field_number = cur_field;
      result.char_offset  = offset;
      byte4_m_next = b4_upd;
      byte5_c_next = b5_upd;
      if (is_comma) begin
        result.field_end = rmc & in_range;
        if (cur_field != FIELD_MAX) cur_field_next = cur_field + 4'd1;
        offset_next = 8'd0;
      end else if (is_lf && rmc) begin
        result.sentence_done = 1'b1;
        committed_fix_next   = pending_fix;
        open_next            = 1'b0;
      end else begin
        if (rmc && in_range) begin
          result.field_char = 1'b1;
          // first character of the status field carries the fix flag
          if (cur_field == FIX_FIELD && offset == 8'd0) begin
            if (rx_byte == CH_A)      pending_fix_next = 1'b1;
            else if (rx_byte == CH_V) pending_fix_next = 1'b0;
          end
        end
        if (offset != OFFSET_MAX) offset_next = offset + 8'd1;
      end
      if (open_next) begin
        line_pos_next = pos_inc;
        if (pos_inc >= LPW'(MAX_LINE)) open_next = 1'b0;
      end
    end
    result.fix_valid = committed_fix_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_open     <= 1'b0;
      line_pos      <= '0;
      byte4_m       <= 1'b0;
      byte5_c       <= 1'b0;
      cur_field     <= 4'd0;
      offset        <= 8'd0;
      pending_fix   <= 1'b0;
      committed_fix <= 1'b0;
    end else if (en) begin
      line_open     <= open_next;
      line_pos      <= line_pos_next;
      byte4_m       <= byte4_m_next;
      byte5_c       <= byte5_c_next;
      cur_field     <= cur_field_next;
      offset        <= offset_next;
      pending_fix   <= pending_fix_next;
      committed_fix <= committed_fix_next;
    end
  end

endmodule

// ----- rtl/core/nrmc_out_reg.sv -----
// Result register: holds one tagged item until the downstream side takes it.
// Depends on nrmc_pkg.
module nrmc_out_reg import nrmc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t load_data,
  input  logic    take,
  output logic    full,
  output result_t data
);

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (load) begin
      full <= 1'b1;
    end else if (take) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= load_data;
    end
  end

endmodule

// ----- rtl/core/nmea_rmc_field_extractor.sv -----
// NMEA RMC field extractor. Takes one received UART character per item and
// returns one tagged item per character, in order. A '$' opens a line; the line
// is an RMC sentence when line bytes 4 and 5 are 'M' and 'C'. Characters of
// fields 1 to 8 are flagged with their field number and offset, the comma that
// closes such a field is flagged as a field end, and a line feed ends the
// sentence (tlast) and commits the fix flag taken from field 2 ('A' sets,
// 'V' clears). A line that runs to 250 bytes without a line feed is dropped
// until the next '$'. Throughput is one item per clock while m_tready is high.
// An accepted item is held in the input register and is then loaded into the
// result register, which drives tvalid, once that register is empty or its item
// is being taken. The sentence state is updated as each item moves between the
// two registers.
// Both registers accept a new item in the same cycle the old one leaves.
// Depends on nrmc_pkg, nrmc_parser, nrmc_out_reg and the assertion header.
`include "nmea_rmc_field_extractor_assert.svh"
module nmea_rmc_field_extractor import nrmc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [3:0] field_number, [11:4] char_offset,
                                 // [19:12] data_byte, [20] fix_valid, [23:21] zero
  output logic [1:0]  m_tuser,   // [0] field_char, [1] field_end
  output logic        m_tlast    // sentence_done
);

  // input register
  logic       in_full;
  logic [7:0] in_byte;
  logic       advance;     // item moves from input register to result register
  logic       out_full;
  result_t    res_comb;
  result_t    res_q;
  logic       line_open;

  assign advance  = in_full && (!out_full || m_tready);
  assign s_tready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (s_tready) begin
      in_full <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  // sentence state advances once per item, in arrival order
  nrmc_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .rx_byte   (in_byte),
    .result    (res_comb),
    .line_open (line_open)
  );

  nrmc_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .load_data (res_comb),
    .take      (m_tready),
    .full      (out_full),
    .data      (res_q)
  );

  assign m_tvalid = out_full;
  assign m_tdata  = {3'b000, res_q.fix_valid, res_q.data_byte, res_q.char_offset,
                     res_q.field_number};
  assign m_tuser  = {res_q.field_end, res_q.field_char};
  assign m_tlast  = res_q.sentence_done;

  // a tagged character is never also a field end or a sentence end
  `NRMC_ASSERT_IMP(a_tag_excl, clk, rst, m_tvalid && m_tuser[0], !m_tuser[1] && !m_tlast)
  // tagged items always lie in fields 1 to LAST_FIELD
  `NRMC_ASSERT_IMP(a_tag_range, clk, rst, m_tvalid && (m_tuser[0] || m_tuser[1]),
    (m_tdata[3:0] != 4'd0) && (m_tdata[3:0] <= 4'(LAST_FIELD)))
  // a closed line stays closed until a '$' passes
  `NRMC_ASSERT_NXT(a_closed, clk, rst, !line_open && !(advance && in_byte == CH_DOLLAR),
    !line_open)
  // a '$' is reported at field 0, offset 0, and never tagged
  `NRMC_ASSERT_IMP(a_dollar, clk, rst, m_tvalid && (m_tdata[19:12] == CH_DOLLAR),
    (m_tdata[11:0] == 12'd0) && (m_tuser == 2'b00) && !m_tlast)

endmodule
